FILE: hdl/sltc_pkg.sv
package sltc_pkg;

    localparam int STORE_BYTES_DEF    = 65536;
    localparam int MAX_ROW_PIXELS_DEF = 1024;
    localparam int FRAC_BITS          = 16;

    localparam int COUNT_W     = 21;
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_INDEX_W = 1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH     = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_WHITE_THRESHOLD = 1'b1;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_RUN   = 1'b1;

    localparam int         IMAGE_WIDTH_RESET     = 1024;
    localparam logic [7:0] WHITE_THRESHOLD_RESET = 8'd128;

    typedef struct packed {
        logic               command;
        logic [15:0]        pixel_address;
        logic [7:0]         pixel_value;
        logic [9:0]         start_x;
        logic [11:0]        start_y;
        logic [10:0]        run_width;
        logic [10:0]        delta_x;
        logic [10:0]        delta_y;
        logic signed [1:0]  step_y;
        logic signed [31:0] gradient;
    } t_in_item;

    typedef struct packed {
        logic take;
        logic step;
        logic flag_fault;
        logic load_out;
    } t_ctrl_cmd;

    typedef struct packed {
        logic more;
        logic in_range;
        logic pipe_empty;
        logic out_free;
    } t_dp_status;

endpackage

FILE: hdl/sltc_ifs.sv
interface sltc_item_if;
    logic               valid;
    logic               ready;
    logic               command;
    logic [15:0]        pixel_address;
    logic [7:0]         pixel_value;
    logic [9:0]         start_x;
    logic [11:0]        start_y;
    logic [10:0]        run_width;
    logic [10:0]        delta_x;
    logic [10:0]        delta_y;
    logic signed [1:0]  step_y;
    logic signed [31:0] gradient;

    modport source (
        output valid, command, pixel_address, pixel_value, start_x, start_y,
               run_width, delta_x, delta_y, step_y, gradient,
        input  ready
    );
    modport sink (
        input  valid, command, pixel_address, pixel_value, start_x, start_y,
               run_width, delta_x, delta_y, step_y, gradient,
        output ready
    );
endinterface

interface sltc_result_if;
    logic        valid;
    logic        ready;
    logic [20:0] white_count;
    logic [20:0] black_count;
    logic        range_error;

    modport source (
        output valid, white_count, black_count, range_error,
        input  ready
    );
    modport sink (
        input  valid, white_count, black_count, range_error,
        output ready
    );
endinterface

FILE: hdl/sltc_ctrl.sv
module sltc_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_command,
    input  sltc_pkg::t_dp_status  i_status,
    output sltc_pkg::t_ctrl_cmd   o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                o_cmd.take = 1'b1;
                if (i_in_valid && (i_in_command == sltc_pkg::CMD_RUN)) begin
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (!i_status.more) begin
                    n_state = ST_DONE;
                end else if (!i_status.in_range) begin
                    // The sample would read outside the store: stop here.
                    o_cmd.flag_fault = 1'b1;
                    n_state          = ST_DONE;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            ST_DONE: begin
                if (i_status.pipe_empty && i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: hdl/sltc_datapath.sv
module sltc_datapath #(
    parameter int STORE_BYTES    = sltc_pkg::STORE_BYTES_DEF,
    parameter int MAX_ROW_PIXELS = sltc_pkg::MAX_ROW_PIXELS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [sltc_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [sltc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    input  sltc_pkg::t_in_item                  i_item,
    input  sltc_pkg::t_ctrl_cmd                 i_cmd,
    output sltc_pkg::t_dp_status                o_status,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [sltc_pkg::COUNT_W-1:0]        o_white_count,
    output logic [sltc_pkg::COUNT_W-1:0]        o_black_count,
    output logic                                o_range_error
);

    localparam int AW  = $clog2(STORE_BYTES);
    localparam int IWW = $clog2(MAX_ROW_PIXELS + 1);
    localparam int UB1 = $clog2(4096 * MAX_ROW_PIXELS + 1024);
    localparam int UB2 = $clog2(STORE_BYTES + 2 * MAX_ROW_PIXELS + 2);
    localparam int BW  = ((UB1 > UB2) ? UB1 : UB2) + 1;
    localparam int XW  = 12;
    localparam int EW  = 14;
    localparam int MAG_W    = 33;
    localparam int PROD_W   = 9 + MAG_W + 1;
    localparam int SAMPLE_W = PROD_W - sltc_pkg::FRAC_BITS + 1;
    localparam int IW_RESET = (sltc_pkg::IMAGE_WIDTH_RESET > MAX_ROW_PIXELS) ?
                              MAX_ROW_PIXELS : sltc_pkg::IMAGE_WIDTH_RESET;

    // Configuration.
    logic [IWW-1:0] r_iw;
    logic [7:0]     r_thresh;
    logic [IWW-1:0] w_iw_sat;

    assign w_iw_sat = (32'(i_cfg_data) > 32'(MAX_ROW_PIXELS)) ?
                      IWW'(MAX_ROW_PIXELS) : IWW'(i_cfg_data);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iw     <= IWW'(IW_RESET);
            r_thresh <= sltc_pkg::WHITE_THRESHOLD_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sltc_pkg::REG_IMAGE_WIDTH:     r_iw     <= w_iw_sat;
                sltc_pkg::REG_WHITE_THRESHOLD: r_thresh <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Pixel store.
    logic [7:0]    r_mem [STORE_BYTES];
    logic          w_take;
    logic          w_start;
    logic          w_wr_ok;
    logic [AW-1:0] w_wr_addr;

    assign w_take    = i_cmd.take && i_in_valid;
    assign w_start   = w_take && (i_item.command == sltc_pkg::CMD_RUN);
    assign w_wr_ok   = 32'(i_item.pixel_address) < 32'(STORE_BYTES);
    assign w_wr_addr = AW'(i_item.pixel_address);

    always_ff @(posedge i_clk) begin
        if (w_take && (i_item.command == sltc_pkg::CMD_WRITE) && w_wr_ok) begin
            r_mem[w_wr_addr] <= i_item.pixel_value;
        end
    end

    // Walk state.
    logic signed [BW-1:0]  r_base;
    logic [XW-1:0]         r_x;
    logic [XW-1:0]         r_endx;
    logic signed [EW-1:0]  r_err;
    logic [10:0]           r_dx;
    logic [10:0]           r_dy;
    logic signed [1:0]     r_step;
    logic signed [31:0]    r_grad;
    logic signed [31:0]    r_blend;
    logic                  r_fault;

    logic signed [BW-1:0]  w_base_init;
    logic signed [BW-1:0]  w_iw_s;
    logic signed [BW-1:0]  w_other;
    logic signed [BW-1:0]  w_row_off;
    logic signed [BW-1:0]  n_base;
    logic                  w_base_ok;
    logic                  w_other_ok;
    logic signed [EW:0]    w_e2;
    logic signed [EW:0]    w_dx_s;
    logic signed [EW:0]    w_dy_s;
    logic                  w_x_adv;
    logic                  w_y_adv;
    logic signed [EW-1:0]  n_err;
    logic signed [31:0]    w_step_wt;
    logic signed [31:0]    n_blend;
    logic [MAG_W-1:0]      w_mag;

    assign w_base_init = BW'($signed({1'b0, i_item.start_y})) * BW'($signed({1'b0, r_iw}))
                       + BW'($signed({1'b0, i_item.start_x}));

    assign w_iw_s  = BW'($signed({1'b0, r_iw}));
    // A negative weight blends toward the row above, otherwise the row below.
    assign w_other = r_blend[31] ? (r_base - w_iw_s) : (r_base + w_iw_s);

    assign w_base_ok  = !r_base[BW-1] && (r_base < BW'(STORE_BYTES));
    assign w_other_ok = !w_other[BW-1] && (w_other < BW'(STORE_BYTES));

    assign w_e2    = {r_err, 1'b0};
    assign w_dx_s  = (EW+1)'($signed({1'b0, r_dx}));
    assign w_dy_s  = (EW+1)'($signed({1'b0, r_dy}));
    assign w_x_adv = w_e2 > -w_dy_s;
    assign w_y_adv = w_e2 < w_dx_s;

    assign n_err = r_err - (w_x_adv ? EW'($signed({1'b0, r_dy})) : EW'(0))
                         + (w_y_adv ? EW'($signed({1'b0, r_dx})) : EW'(0));

    always_comb begin
        case (r_step)
            2'sb01:  w_row_off = w_iw_s;
            2'sb11:  w_row_off = -w_iw_s;
            2'sb10:  w_row_off = -(w_iw_s <<< 1);
            default: w_row_off = '0;
        endcase
    end

    assign n_base = r_base + (w_x_adv ? BW'(1) : BW'(0)) + (w_y_adv ? w_row_off : BW'(0));

    // Each y step pulls the weight back by one whole row in the step direction.
    assign w_step_wt = 32'(r_step) <<< sltc_pkg::FRAC_BITS;
    assign n_blend   = r_blend + r_grad - (w_y_adv ? w_step_wt : 32'sd0);
    assign w_mag     = r_blend[31] ? (MAG_W'(0) - MAG_W'({r_blend[31], r_blend}))
                                   : MAG_W'({1'b0, r_blend});

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_base  <= w_base_init;
            r_x     <= XW'(i_item.start_x);
            r_endx  <= XW'(i_item.start_x) + XW'(i_item.run_width);
            r_err   <= EW'($signed({1'b0, i_item.delta_x})) - EW'($signed({1'b0, i_item.delta_y}));
            r_dx    <= i_item.delta_x;
            r_dy    <= i_item.delta_y;
            r_step  <= i_item.step_y;
            r_grad  <= i_item.gradient;
            r_blend <= '0;
        end else if (i_cmd.step) begin
            r_base  <= n_base;
            r_x     <= w_x_adv ? (r_x + XW'(1)) : r_x;
            r_err   <= n_err;
            r_blend <= n_blend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fault <= 1'b0;
        end else if (w_start) begin
            r_fault <= (i_item.run_width != '0) && (i_item.delta_x == '0);
        end else if (i_cmd.flag_fault) begin
            r_fault <= 1'b1;
        end
    end

    // Read stage: both pixels of a sample and the weight magnitude.
    logic [7:0]       r_rd_a;
    logic [7:0]       r_rd_b;
    logic [MAG_W-1:0] r_mag_b;
    logic             r_b_valid;

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_rd_a  <= r_mem[r_base[AW-1:0]];
            r_rd_b  <= r_mem[w_other[AW-1:0]];
            r_mag_b <= w_mag;
        end
    end

    // Multiply stage.
    logic signed [8:0]        w_diff;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [PROD_W-1:0] r_prod;
    logic [7:0]               r_va_c;
    logic                     r_c_valid;

    assign w_diff = $signed({1'b0, r_rd_b}) - $signed({1'b0, r_rd_a});
    assign w_prod = PROD_W'(w_diff) * PROD_W'($signed({1'b0, r_mag_b}));

    always_ff @(posedge i_clk) begin
        if (r_b_valid) begin
            r_prod <= w_prod;
            r_va_c <= r_rd_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            r_b_valid <= i_cmd.step;
            r_c_valid <= r_b_valid;
        end
    end

    // Threshold and count stage. The arithmetic shift floors toward minus infinity.
    logic signed [SAMPLE_W-1:0]     w_sample;
    logic                           w_white;
    logic [sltc_pkg::COUNT_W-1:0]   r_white;
    logic [sltc_pkg::COUNT_W-1:0]   r_black;

    assign w_sample = SAMPLE_W'(r_prod >>> sltc_pkg::FRAC_BITS)
                    + SAMPLE_W'($signed({1'b0, r_va_c}));
    assign w_white  = w_sample > SAMPLE_W'($signed({1'b0, r_thresh}));

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_white <= '0;
            r_black <= '0;
        end else if (r_c_valid) begin
            if (w_white) begin
                if (r_white != sltc_pkg::COUNT_MAX) begin
                    r_white <= r_white + 1'b1;
                end
            end else if (r_black != sltc_pkg::COUNT_MAX) begin
                r_black <= r_black + 1'b1;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_white_count <= r_white;
            o_black_count <= r_black;
            o_range_error <= r_fault;
        end
    end

    assign o_status.more       = (r_x < r_endx) && !r_fault;
    assign o_status.in_range   = w_base_ok && w_other_ok;
    assign o_status.pipe_empty = !r_b_valid && !r_c_valid;
    assign o_status.out_free   = !o_out_valid || i_out_ready;

endmodule

FILE: hdl/subpixel_line_threshold_counter_unit.sv
// Channel   Role    Payload
// i_in      sink    command, pixel_address, pixel_value, start_x, start_y, run_width,
//                   delta_x, delta_y, step_y, gradient
// o_out     source  white_count, black_count, range_error (one item per run)
// i_cfg_*   write   image_width (index 0), white_threshold (index 1)
//
// Pixel write items stream at one per cycle while no run is in progress.
// A run item is walked at one sample per cycle into a read, multiply and count pipeline
// fed by the store's two read ports.
// Reset is synchronous and clears control state only; the pixel store is not cleared.
// A finished result waits in the output register, and a new item is taken while it waits;
// the next run holds at its end until that register is free.
module subpixel_line_threshold_counter_unit #(
    parameter int STORE_BYTES    = sltc_pkg::STORE_BYTES_DEF,
    parameter int MAX_ROW_PIXELS = sltc_pkg::MAX_ROW_PIXELS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [sltc_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [sltc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    sltc_item_if.sink                        i_in,
    sltc_result_if.source                    o_out
);

    sltc_pkg::t_in_item   w_item;
    sltc_pkg::t_ctrl_cmd  w_cmd;
    sltc_pkg::t_dp_status w_status;

    assign w_item.command       = i_in.command;
    assign w_item.pixel_address = i_in.pixel_address;
    assign w_item.pixel_value   = i_in.pixel_value;
    assign w_item.start_x       = i_in.start_x;
    assign w_item.start_y       = i_in.start_y;
    assign w_item.run_width     = i_in.run_width;
    assign w_item.delta_x       = i_in.delta_x;
    assign w_item.delta_y       = i_in.delta_y;
    assign w_item.step_y        = i_in.step_y;
    assign w_item.gradient      = i_in.gradient;

    assign i_in.ready = w_cmd.take;

    sltc_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in.valid),
        .i_in_command (i_in.command),
        .i_status     (w_status),
        .o_cmd        (w_cmd)
    );

    sltc_datapath #(
        .STORE_BYTES    (STORE_BYTES),
        .MAX_ROW_PIXELS (MAX_ROW_PIXELS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in.valid),
        .i_item        (w_item),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_white_count (o_out.white_count),
        .o_black_count (o_out.black_count),
        .o_range_error (o_out.range_error)
    );

endmodule

FILE: hdl/sltc_checker.sv
module sltc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_in_command,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [20:0] i_white_count,
    input logic [20:0] i_black_count,
    input logic        i_range_error
);

    // A result item stays offered until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result item dropped before it was taken");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            ($stable(i_white_count) && $stable(i_black_count) && $stable(i_range_error)))
        else $error("result item changed while stalled");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result pending after reset");

    // A run item occupies the block, so the next item must wait.
    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && (i_in_command == sltc_pkg::CMD_RUN)) |=> !i_in_ready)
        else $error("item taken during a line walk");

    // Pixel writes stream without a gap.
    a_write_stream: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && (i_in_command == sltc_pkg::CMD_WRITE)) |=> i_in_ready)
        else $error("pixel write item stalled the input");

endmodule

bind subpixel_line_threshold_counter_unit sltc_checker u_sltc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_in_command  (i_in.command),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_white_count (o_out.white_count),
    .i_black_count (o_out.black_count),
    .i_range_error (o_out.range_error)
);

FILE: dv/sltc_line_checker.sv
module sltc_line_checker
    import sltc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    sltc_item_if                   i_item,
    sltc_result_if                 i_result,
    output int                     o_mismatches,
    output int                     o_open_results,
    output int                     o_checked_results
);

    typedef struct packed {
        logic [COUNT_W-1:0] white_count;
        logic [COUNT_W-1:0] black_count;
        logic               range_error;
    } t_line_counts;

    logic [7:0]            pixel_mem [STORE_BYTES_DEF];
    logic [CFG_DATA_W-1:0] row_stride;
    logic [7:0]            white_level;
    t_line_counts          line_counts_q [$];
    int                    mismatches = 0;
    int                    checked = 0;

    // Walks the line over the mirrored image and counts light and dark samples.
    function automatic t_line_counts walk_line(input t_in_item it);
        t_line_counts res;
        longint       x, y, end_x, err, e2, dx, dy, stride;
        longint       base, other, mag, va, vb, level;
        int           blend, step;
        bit           fault;
        res    = '0;
        dx     = longint'(it.delta_x);
        dy     = longint'(it.delta_y);
        stride = (row_stride > MAX_ROW_PIXELS_DEF) ? MAX_ROW_PIXELS_DEF : row_stride;
        step   = int'($signed(it.step_y));
        x      = longint'(it.start_x);
        y      = longint'(it.start_y);
        end_x  = x + longint'(it.run_width);
        err    = dx - dy;
        blend  = 0;
        fault  = (it.run_width != 0) && (dx == 0);
        while (!fault && x < end_x) begin
            base  = y * stride + x;
            mag   = (blend < 0) ? -longint'(blend) : longint'(blend);
            other = (blend < 0) ? base - stride : base + stride;
            if (base < 0 || base >= STORE_BYTES_DEF || other < 0 || other >= STORE_BYTES_DEF) begin
                fault = 1'b1;
            end else begin
                va = longint'(pixel_mem[base]);
                vb = longint'(pixel_mem[other]);
                // The arithmetic shift of a signed product rounds toward minus infinity.
                level = va + (((vb - va) * mag) >>> FRAC_BITS);
                if (level > longint'(white_level)) begin
                    if (res.white_count != COUNT_MAX) res.white_count++;
                end else if (res.black_count != COUNT_MAX) begin
                    res.black_count++;
                end
                e2 = 2 * err;
                if (e2 > -dy) begin
                    err -= dy;
                    x++;
                end
                if (e2 < dx) begin
                    err += dx;
                    y += step;
                    blend = blend - step * (1 << FRAC_BITS);
                end
                blend = blend + int'($signed(it.gradient));
            end
        end
        res.range_error = fault;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_in_item     seen;
        t_line_counts expected;
        if (!i_rst_n) begin
            row_stride  = CFG_DATA_W'(IMAGE_WIDTH_RESET);
            white_level = WHITE_THRESHOLD_RESET;
            line_counts_q.delete();
        end else begin
            if (i_result.valid && i_result.ready) begin
                checked++;
                if (line_counts_q.size() == 0) begin
                    $error("line result with no run waiting: white_count %0d, black_count %0d",
                           i_result.white_count, i_result.black_count);
                    mismatches++;
                end else begin
                    expected = line_counts_q.pop_front();
                    if (i_result.white_count !== expected.white_count) begin
                        $error("white_count: expected %0d, got %0d",
                               expected.white_count, i_result.white_count);
                        mismatches++;
                    end
                    if (i_result.black_count !== expected.black_count) begin
                        $error("black_count: expected %0d, got %0d",
                               expected.black_count, i_result.black_count);
                        mismatches++;
                    end
                    if (i_result.range_error !== expected.range_error) begin
                        $error("range_error: expected %0d, got %0d",
                               expected.range_error, i_result.range_error);
                        mismatches++;
                    end
                end
            end
            if (i_item.valid && i_item.ready) begin
                seen.command       = i_item.command;
                seen.pixel_address = i_item.pixel_address;
                seen.pixel_value   = i_item.pixel_value;
                seen.start_x       = i_item.start_x;
                seen.start_y       = i_item.start_y;
                seen.run_width     = i_item.run_width;
                seen.delta_x       = i_item.delta_x;
                seen.delta_y       = i_item.delta_y;
                seen.step_y        = i_item.step_y;
                seen.gradient      = i_item.gradient;
                if (seen.command == CMD_WRITE) begin
                    pixel_mem[seen.pixel_address] = seen.pixel_value;
                end else begin
                    line_counts_q.push_back(walk_line(seen));
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_IMAGE_WIDTH: begin
                        row_stride = i_cfg_data;
                    end
                    REG_WHITE_THRESHOLD: begin
                        white_level = i_cfg_data[7:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
        o_mismatches      <= mismatches;
        o_open_results    <= line_counts_q.size();
        o_checked_results <= checked;
    end

endmodule

FILE: dv/tb.sv
module tb;
    import sltc_pkg::*;

    localparam int IDLE_LIMIT      = 50000;
    localparam int SETTLE_CYCLES   = 16;
    localparam int ITEMS_PER_PHASE = 180;
    localparam int MAX_WALK        = 4096;
    localparam int FILL_BUDGET     = 40;

    localparam logic signed [1:0] STEP_DOWN   = 2'sb01;
    localparam logic signed [1:0] STEP_FLAT   = 2'sb00;
    localparam logic signed [1:0] STEP_UP     = 2'sb11;
    localparam logic signed [1:0] STEP_UP_TWO = 2'sb10;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    int mismatch_count;
    int open_results;
    int checked_results;
    int burst_left = 0;
    int n_writes = 0;
    int n_runs = 0;
    int n_items = 0;
    int n_settings = 1;
    int idle_cycles = 0;
    int stall_mode = 0;
    int stall_left = 0;
    int cur_stride = IMAGE_WIDTH_RESET;
    logic [2:0] stall_phase = '0;
    bit written [STORE_BYTES_DEF];

    sltc_item_if   item_ch ();
    sltc_result_if result_ch ();

    subpixel_line_threshold_counter_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in        (item_ch),
        .o_out       (result_ch)
    );

    sltc_line_checker u_line_check (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .i_item            (item_ch),
        .i_result          (result_ch),
        .o_mismatches      (mismatch_count),
        .o_open_results    (open_results),
        .o_checked_results (checked_results)
    );

    always #5 i_clk = ~i_clk;

    // The result side cycles through stall patterns of random duration.
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(50, 600);
        end else begin
            stall_left <= stall_left - 1;
        end
        stall_phase <= stall_phase + 3'd1;
        case (stall_mode)
            0: result_ch.ready <= 1'b1;
            1: result_ch.ready <= ($urandom_range(0, 3) != 0);
            2: result_ch.ready <= (stall_phase == 3'd0);
            default: result_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no item moved for %0d cycles", IDLE_LIMIT);
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic t_in_item any_item(input logic cmd);
        t_in_item it;
        it.command       = cmd;
        it.pixel_address = 16'($urandom);
        it.pixel_value   = 8'($urandom);
        it.start_x       = 10'($urandom);
        it.start_y       = 12'($urandom);
        it.run_width     = 11'($urandom_range(0, 1024));
        it.delta_x       = 11'($urandom_range(0, 1024));
        it.delta_y       = 11'($urandom_range(0, 1024));
        it.step_y        = 2'($urandom);
        it.gradient      = $urandom;
        return it;
    endfunction

    function automatic t_in_item line_run(input int sx, input int sy, input int w, input int dx,
                                          input int dy, input logic signed [1:0] step,
                                          input logic [31:0] grad);
        t_in_item it;
        it           = any_item(CMD_RUN);
        it.start_x   = 10'(sx);
        it.start_y   = 12'(sy);
        it.run_width = 11'(w);
        it.delta_x   = 11'(dx);
        it.delta_y   = 11'(dy);
        it.step_y    = step;
        it.gradient  = grad;
        return it;
    endfunction

    function automatic t_in_item pixel_write(input int addr, input int value);
        t_in_item it;
        it               = any_item(CMD_WRITE);
        it.pixel_address = 16'(addr);
        it.pixel_value   = 8'(value);
        return it;
    endfunction

    // Follows the walk's path at the current stride and returns the first store address
    // that it would read before that pixel was written, or -1 when there is none.
    function automatic int first_unwritten(input t_in_item it);
        longint x, y, end_x, err, e2, dx, dy, base, other;
        int     blend, step;
        dx    = longint'(it.delta_x);
        dy    = longint'(it.delta_y);
        step  = int'(it.step_y);
        x     = longint'(it.start_x);
        y     = longint'(it.start_y);
        end_x = x + longint'(it.run_width);
        err   = dx - dy;
        blend = 0;
        if (dx == 0) return -1;
        while (x < end_x) begin
            base  = y * cur_stride + x;
            other = (blend < 0) ? base - cur_stride : base + cur_stride;
            if (base < 0 || base >= STORE_BYTES_DEF || other < 0 || other >= STORE_BYTES_DEF) begin
                return -1;
            end
            if (!written[base]) return int'(base);
            if (!written[other]) return int'(other);
            e2 = 2 * err;
            if (e2 > -dy) begin
                err -= dy;
                x++;
            end
            if (e2 < dx) begin
                err += dx;
                y += step;
                blend = blend - step * (1 << FRAC_BITS);
            end
            blend = blend + int'(it.gradient);
        end
        return -1;
    endfunction

    // The sender works in bursts; a gap of zero keeps valid high into the next burst.
    task automatic send_item(input t_in_item it);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                item_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 32);
        end
        item_ch.command       <= it.command;
        item_ch.pixel_address <= it.pixel_address;
        item_ch.pixel_value   <= it.pixel_value;
        item_ch.start_x       <= it.start_x;
        item_ch.start_y       <= it.start_y;
        item_ch.run_width     <= it.run_width;
        item_ch.delta_x       <= it.delta_x;
        item_ch.delta_y       <= it.delta_y;
        item_ch.step_y        <= it.step_y;
        item_ch.gradient      <= it.gradient;
        item_ch.valid         <= 1'b1;
        do @(posedge i_clk); while (!item_ch.ready);
        burst_left--;
        n_items++;
        if (it.command == CMD_WRITE) begin
            n_writes++;
            written[it.pixel_address] = 1'b1;
        end else begin
            n_runs++;
        end
    endtask

    // Every pixel that a walk reads is written first; a walk that would need too many
    // writes is shortened until its path is covered.
    task automatic send_run(input t_in_item it);
        t_in_item run_it;
        int       addr;
        int       fills;
        run_it = it;
        fills  = 0;
        addr   = first_unwritten(run_it);
        while (addr >= 0) begin
            if (fills >= FILL_BUDGET) begin
                run_it.run_width = run_it.run_width >> 1;
            end else begin
                send_item(pixel_write(addr, $urandom_range(0, 255)));
                fills++;
            end
            addr = first_unwritten(run_it);
        end
        send_item(run_it);
    endtask

    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (open_results != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(input int stride, input int level);
        t_in_item it;
        int       eff, rows, pick, slope, win_x, win_y, first_item;
        wait_drained();
        n_settings++;
        cfg_we    <= 1'b1;
        cfg_index <= REG_IMAGE_WIDTH;
        cfg_data  <= CFG_DATA_W'(stride);
        @(posedge i_clk);
        cfg_index <= REG_WHITE_THRESHOLD;
        cfg_data  <= CFG_DATA_W'(level);
        @(posedge i_clk);
        cfg_we <= 1'b0;
        eff  = (stride > MAX_ROW_PIXELS_DEF) ? MAX_ROW_PIXELS_DEF : stride;
        cur_stride = eff;
        rows = (eff == 0) ? 4096 : STORE_BYTES_DEF / eff;
        if (rows > 4096) rows = 4096;
        // Walks start in a small window so that the pixels they read are reused.
        win_x = $urandom_range(0, 1000);
        pick  = $urandom_range(0, 2);
        win_y = (pick == 0) ? 0 : (pick == 1) ? rows - 4 : $urandom_range(1, rows - 40);
        first_item = n_items;
        while (n_items - first_item < ITEMS_PER_PHASE) begin
            pick = $urandom_range(0, 9);
            if (pick < 3) begin
                send_item(any_item(CMD_WRITE));
            end else if (pick < 9) begin
                // Well-formed walk: starts inside the window with a moderate slope.
                it           = any_item(CMD_RUN);
                it.start_x   = 10'(win_x + $urandom_range(0, 15));
                it.start_y   = 12'(win_y + $urandom_range(0, 3));
                it.delta_x   = 11'($urandom_range(1, 16));
                it.delta_y   = 11'($urandom_range(0, 2 * it.delta_x));
                it.run_width = 11'(($urandom_range(0, 9) == 0) ? $urandom_range(17, 64)
                                                               : $urandom_range(0, 16));
                pick = $urandom_range(0, 9);
                it.step_y = (pick < 3) ? STEP_DOWN : (pick < 6) ? STEP_UP :
                            (pick < 9) ? STEP_FLAT : STEP_UP_TWO;
                it.gradient = ($urandom_range(0, 3) == 0) ? $urandom :
                              32'($urandom_range(0, 32'h40000)) - 32'h20000;
                send_run(it);
            end else begin
                // Unconstrained walk, shortened so that steep slopes stay affordable.
                it = any_item(CMD_RUN);
                if (it.delta_x != 0) begin
                    slope = it.delta_y / it.delta_x + 1;
                    if (it.run_width * slope > MAX_WALK) it.run_width = 11'(MAX_WALK / slope);
                end
                send_run(it);
            end
        end
    endtask

    initial begin
        item_ch.valid         = 1'b0;
        item_ch.command       = CMD_WRITE;
        item_ch.pixel_address = '0;
        item_ch.pixel_value   = '0;
        item_ch.start_x       = '0;
        item_ch.start_y       = '0;
        item_ch.run_width     = '0;
        item_ch.delta_x       = '0;
        item_ch.delta_y       = '0;
        item_ch.step_y        = '0;
        item_ch.gradient      = '0;
        result_ch.ready       = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_run(line_run(7, 3, 0, 0, 0, STEP_FLAT, 32'h0));
        send_run(line_run(7, 3, 0, 5, 2, STEP_DOWN, 32'h0));
        send_run(line_run(7, 3, 7, 0, 4, STEP_DOWN, 32'h0));
        send_run(line_run(0, 1, 1024, 1024, 0, STEP_FLAT, 32'h0000_0100));
        send_run(line_run(10, 2, 3, 1, 1024, STEP_DOWN, 32'h0000_4000));
        send_run(line_run(5, 60, 20, 4, 4, STEP_UP_TWO, 32'h0000_8000));
        // A negative weight on row zero reads above the store.
        send_run(line_run(3, 0, 10, 10, 0, STEP_FLAT, 32'hFFFF_8000));
        // The row below the last one lies past the end of the store.
        send_run(line_run(1000, 63, 4, 4, 0, STEP_FLAT, 32'h0));
        send_run(line_run(100, 20, 8, 8, 3, STEP_DOWN, 32'h7FFF_FFFF));
        send_run(line_run(200, 20, 8, 8, 3, STEP_UP, 32'h8000_0000));
        send_run(line_run(1023, 63, 1024, 1024, 1024, STEP_UP, 32'h0001_0000));
        send_run(line_run(1023, 4095, 5, 3, 1, STEP_DOWN, 32'h0));
        send_item(pixel_write(0, 255));
        send_item(pixel_write(1024, 0));
        send_run(line_run(0, 0, 2, 1, 0, STEP_FLAT, 32'h0000_8000));
        send_item(pixel_write(65535, 0));
        send_run(line_run(1023, 62, 1, 1, 0, STEP_FLAT, 32'h0001_0000));

        run_phase(16, 0);
        run_phase(0, 255);
        run_phase(2047, 77);
        run_phase(1, 200);
        run_phase(1024, $urandom_range(0, 255));
        run_phase($urandom_range(2, 1023), $urandom_range(0, 255));

        wait_drained();
        $display("Covered %0d pixel writes and %0d line walks under %0d register settings,",
                 n_writes, n_runs, n_settings);
        $display("with %0d line results compared field by field.", checked_results);
        if (mismatch_count == 0 && open_results == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

FILE: files.f
hdl/sltc_pkg.sv
hdl/sltc_ifs.sv
hdl/sltc_ctrl.sv
hdl/sltc_datapath.sv
hdl/subpixel_line_threshold_counter_unit.sv
hdl/sltc_checker.sv
dv/sltc_line_checker.sv
dv/tb.sv
